[rtl/core/fwsc_pkg.sv]
`default_nettype none

package fwsc_pkg;

  // Device command codes
  localparam logic [5:0] CMD_RESET   = 6'h16;
  localparam logic [5:0] CMD_INC     = 6'h06;
  localparam logic [5:0] CMD_PROGRAM = 6'h08;
  localparam logic [5:0] CMD_LOAD    = 6'h02;
  localparam logic [5:0] CMD_CONFIG  = 6'h00;

  // Request function codes
  localparam logic [1:0] FUNC_STORE      = 2'd0;
  localparam logic [1:0] FUNC_STORE_PROG = 2'd1;
  localparam logic [1:0] FUNC_RESET      = 2'd2;
  localparam logic [1:0] FUNC_CONFIG     = 2'd3;

  localparam int          LATCH_WORDS_DEF = 32;
  localparam logic [7:0]  PEND_MAX        = 8'd255;

  // Command slots of one plan, in issue order
  localparam int NSLOTS     = 7;
  localparam int SLOT_RESET = 0;
  localparam int SLOT_INC1  = 1;
  localparam int SLOT_PROG1 = 2;
  localparam int SLOT_INC2  = 3;
  localparam int SLOT_LOAD  = 4;
  localparam int SLOT_PROG2 = 5;
  localparam int SLOT_PROG3 = 6;

  typedef struct packed {
    logic [1:0]  func;
    logic [14:0] address;
    logic [15:0] data_word;
  } req_t;

  typedef struct packed {
    logic [5:0]  command;
    logic        has_payload;
    logic [15:0] payload;
    logic [14:0] repeat_count;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [NSLOTS-1:0] slots;
    logic              is_cfg;
    logic [14:0]       inc1_cnt;
    logic [14:0]       inc2_cnt;
    logic [15:0]       payload;
  } plan_t;

endpackage

`default_nettype wire

[rtl/core/flash_word_store_command_sequencer.sv]
`default_nettype none

// Channel    Ports                    Direction  Handshake
// request    in_req, push, full       in         taken when push is high and full low
// command    out_res, empty, pop      out        taken when pop is high and empty low
//
// One request becomes one to seven commands, issued at one command per clock while
// the output queue is not full, so a request holds the issue stage until its last
// command is taken. On its way to the output a request is registered with its
// reciprocal-estimated quotient, planned into the plan queue and then issued into
// the output queue, each of which is registered.
// Reset is synchronous and active low; it empties both queues and clears the
// tracked device address and pending-word count. There is no clearing pass.
// Either side may stall freely; queues between the parts absorb the stalls.

module flash_word_store_command_sequencer
  import fwsc_pkg::*;
#(
  parameter int LATCH_WORDS = LATCH_WORDS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire req_t in_req,
  output logic      full,
  output logic      empty,
  input  wire logic pop,
  output res_t      out_res
);

  plan_t plan_in, plan_out;
  logic  plan_push, plan_full, plan_pop, plan_empty;
  res_t  res;
  logic  res_push, res_full;

  // The front part classifies each request and works out its whole command plan
  // against the tracked device state, which it alone owns.
  fwsc_front #(
    .LATCH_WORDS(LATCH_WORDS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .in_req    (in_req),
    .full      (full),
    .plan_push (plan_push),
    .plan      (plan_in),
    .plan_full (plan_full)
  );

  // A short plan queue decouples planning from issue.
  fwsc_fifo #(
    .WIDTH($bits(plan_t)),
    .DEPTH(2)
  ) u_plan_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (plan_push),
    .wr_data (plan_in),
    .full    (plan_full),
    .rd_en   (plan_pop),
    .rd_data (plan_out),
    .empty   (plan_empty)
  );

  // The back part walks each plan and issues its commands in order.
  fwsc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .plan       (plan_out),
    .plan_empty (plan_empty),
    .plan_pop   (plan_pop),
    .res_push   (res_push),
    .res        (res),
    .res_full   (res_full)
  );

  // The output queue holds finished commands until the consumer takes them.
  fwsc_fifo #(
    .WIDTH($bits(res_t)),
    .DEPTH(2)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_data (res),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (out_res),
    .empty   (empty)
  );

endmodule

`default_nettype wire

[rtl/core/fwsc_fifo.sv]
`default_nettype none

module fwsc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             rd_en,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_wr) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_rd) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

[rtl/core/fwsc_front.sv]
`default_nettype none

module fwsc_front
  import fwsc_pkg::*;
#(
  parameter int LATCH_WORDS = LATCH_WORDS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire req_t  in_req,
  output logic       full,
  output logic       plan_push,
  output plan_t      plan,
  input  wire logic  plan_full
);

  localparam int          AMW   = (LATCH_WORDS > 2) ? $clog2(LATCH_WORDS) : 1;
  localparam int          RSH   = 22;
  localparam int          PW    = 15 + RSH;
  localparam logic [PW-1:0] RECIP = PW'((64'd1 << RSH) / LATCH_WORDS);

  // Stage one: registered request and reciprocal-estimated quotient.
  logic          s1_v_r, s1_v_nxt;
  req_t          s1_req_r;
  logic [14:0]   s1_q_r;
  logic [PW-1:0] prod;
  logic          s1_load;

  // Architectural state of the device as seen by the stream issued so far.
  logic [14:0]    dev_r, dev_nxt;
  logic [AMW-1:0] off_r, off_nxt;
  logic [7:0]     pend_r, pend_nxt;

  logic [14:0]    prod2, r1;
  logic [AMW-1:0] a_mod;
  logic           need_rst, adv, split, row_end;
  logic [14:0]    d;
  logic [AMW-1:0] dm;
  logic [15:0]    b;
  logic [7:0]     p;

  assign prod      = PW'(in_req.address) * RECIP;
  assign plan_push = s1_v_r && !plan_full;
  assign full      = s1_v_r && plan_full;
  assign s1_load   = push && !full;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (s1_load) begin
      s1_v_nxt = 1'b1;
    end else if (plan_push) begin
      s1_v_nxt = 1'b0;
    end
  end

  // The estimate is low by at most one, so the remainder needs one correction.
  always_comb begin
    prod2 = 15'(s1_q_r * 15'(LATCH_WORDS));
    r1    = s1_req_r.address - prod2;
    if (r1 >= 15'(LATCH_WORDS)) begin
      a_mod = AMW'(r1 - 15'(LATCH_WORDS));
    end else begin
      a_mod = AMW'(r1);
    end
  end

  always_comb begin
    need_rst = s1_req_r.address < dev_r;
    d        = need_rst ? '0 : dev_r;
    dm       = need_rst ? '0 : off_r;
    adv      = s1_req_r.address > d;
    b        = {1'b0, d} + 16'(LATCH_WORDS - 1) - 16'(dm);
    split    = (pend_r != '0) && (b < {1'b0, s1_req_r.address});
    row_end  = (a_mod == AMW'(LATCH_WORDS - 1));

    plan          = '0;
    dev_nxt       = dev_r;
    off_nxt       = off_r;
    pend_nxt      = pend_r;
    p             = pend_r;

    case (s1_req_r.func)
      FUNC_STORE, FUNC_STORE_PROG: begin
        plan.slots[SLOT_RESET] = need_rst;
        plan.slots[SLOT_INC1]  = split && (b > {1'b0, d});
        plan.slots[SLOT_PROG1] = split;
        plan.slots[SLOT_INC2]  = adv;
        plan.slots[SLOT_LOAD]  = 1'b1;
        plan.slots[SLOT_PROG2] = row_end;
        plan.slots[SLOT_PROG3] = (s1_req_r.func == FUNC_STORE_PROG);
        plan.inc1_cnt = 15'(b) - d;
        plan.inc2_cnt = split ? s1_req_r.address - 15'(b) : s1_req_r.address - d;
        plan.payload  = {s1_req_r.data_word[14:0], 1'b0};
        if (split) begin
          p = '0;
        end
        if (p != PEND_MAX) begin
          p = p + 1'b1;
        end
        pend_nxt = row_end ? '0 : p;
        dev_nxt  = s1_req_r.address;
        off_nxt  = a_mod;
      end
      FUNC_RESET: begin
        plan.slots[SLOT_RESET] = 1'b1;
        dev_nxt = '0;
        off_nxt = '0;
      end
      default: begin
        plan.slots[SLOT_LOAD] = 1'b1;
        plan.is_cfg  = 1'b1;
        plan.payload = s1_req_r.data_word;
        dev_nxt = '0;
        off_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      dev_r  <= '0;
      off_r  <= '0;
      pend_r <= '0;
    end else begin
      s1_v_r <= s1_v_nxt;
      if (plan_push) begin
        dev_r  <= dev_nxt;
        off_r  <= off_nxt;
        pend_r <= pend_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_req_r <= in_req;
      s1_q_r   <= prod[PW-1:RSH];
    end
  end

endmodule

`default_nettype wire

[rtl/core/fwsc_back.sv]
`default_nettype none

module fwsc_back
  import fwsc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire plan_t plan,
  input  wire logic  plan_empty,
  output logic       plan_pop,
  output logic       res_push,
  output res_t       res,
  input  wire logic  res_full
);

  localparam int SW = $clog2(NSLOTS);

  logic [NSLOTS-1:0] done_r, done_nxt;
  logic [NSLOTS-1:0] cur, selbit;
  logic [SW-1:0]     sel;
  logic              last;

  assign cur      = plan.slots & ~done_r;
  assign selbit   = NSLOTS'(1) << sel;
  assign last     = (cur & ~selbit) == '0;
  assign res_push = !plan_empty && !res_full;
  assign plan_pop = res_push && last;

  always_comb begin
    sel = '0;
    for (int i = NSLOTS - 1; i >= 0; i--) begin
      if (cur[i]) begin
        sel = SW'(i);
      end
    end
  end

  always_comb begin
    res              = '0;
    res.repeat_count = 15'd1;
    res.last         = last;
    case (int'(sel))
      SLOT_RESET: res.command = CMD_RESET;
      SLOT_INC1: begin
        res.command      = CMD_INC;
        res.repeat_count = plan.inc1_cnt;
      end
      SLOT_INC2: begin
        res.command      = CMD_INC;
        res.repeat_count = plan.inc2_cnt;
      end
      SLOT_LOAD: begin
        res.command     = plan.is_cfg ? CMD_CONFIG : CMD_LOAD;
        res.has_payload = 1'b1;
        res.payload     = plan.payload;
      end
      default: res.command = CMD_PROGRAM;
    endcase
  end

  always_comb begin
    done_nxt = done_r;
    if (res_push) begin
      done_nxt = last ? '0 : (done_r | selbit);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= '0;
    end else begin
      done_r <= done_nxt;
    end
  end

endmodule

`default_nettype wire
